@@ hdl/backlight_pulse_dimming_control_macros.svh @@
// Assertion macros shared by the backlight pulse dimming control design.
`ifndef BACKLIGHT_PULSE_DIMMING_CONTROL_MACROS_SVH
`define BACKLIGHT_PULSE_DIMMING_CONTROL_MACROS_SVH

`ifndef SYNTHESIS
`define BPDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BPDC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BPDC_ASSERT(lbl, prop, msg)
`define BPDC_NEVER(lbl, cond, msg)
`endif

`endif

@@ hdl/bpdc_pkg.sv @@
// Shared types, constants and the level-to-step table of the dimming control.
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

    localparam int LEVEL_W     = 8;
    localparam int STEP_W      = 5;
    localparam int CFG_ADDR_W  = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int TABLE_ROWS  = 17;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_LEVEL = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIM_STEP  = 8'd1;

    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 8'd10;
    localparam logic [STEP_W-1:0]  DIM_STEP_RST  = 5'd31;

    // Upper bound of each level band and the tune step for that band.
    localparam logic [LEVEL_W-1:0] LEVEL_BOUND [TABLE_ROWS] = '{
        8'd255, 8'd239, 8'd223, 8'd207, 8'd191, 8'd175, 8'd159, 8'd143, 8'd127,
        8'd114, 8'd102, 8'd90, 8'd78, 8'd66, 8'd54, 8'd42, 8'd30
    };
    localparam logic [STEP_W-1:0] LEVEL_TUNE [TABLE_ROWS] = '{
        5'd9, 5'd9, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
        5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd29, 5'd31
    };

    // Classified request handed from the front end to the back end.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [STEP_W-1:0]  tune;
        logic               power_on;
        logic               line_sense;
    } class_t;

    typedef struct packed {
        logic              applied;
        logic              drop_low_first;
        logic              raise_line;
        logic [STEP_W-1:0] pulse_count;
        logic [STEP_W-1:0] new_step;
        logic              line_high;
    } result_t;

    // Bands are ordered by falling bound, so the last matching row is the tightest one.
    function automatic logic [STEP_W-1:0] table_step(input logic [LEVEL_W-1:0] lv);
        logic [STEP_W-1:0] tune;
        tune = LEVEL_TUNE[0];
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            if (lv <= LEVEL_BOUND[i])
            begin
                tune = LEVEL_TUNE[i];
            end
        end
        return tune;
    endfunction

endpackage

`default_nettype wire

@@ hdl/bpdc_if.sv @@
// Channel interfaces: brightness requests, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface bpdc_req_if
    import bpdc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic               power_on;
    logic               line_sense;

    modport source (output valid, level, power_on, line_sense, input ready);
    modport sink (input valid, level, power_on, line_sense, output ready);
endinterface

interface bpdc_rsp_if
    import bpdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              applied;
    logic              drop_low_first;
    logic              raise_line;
    logic [STEP_W-1:0] pulse_count;
    logic [STEP_W-1:0] new_step;
    logic              line_high;

    modport source (output valid, applied, drop_low_first, raise_line, pulse_count,
                    new_step, line_high, input ready);
    modport sink (input valid, applied, drop_low_first, raise_line, pulse_count,
                  new_step, line_high, output ready);
endinterface

interface bpdc_cfg_if
    import bpdc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ hdl/bpdc_front.sv @@
// Front end: configuration registers and classification of each request item.
`timescale 1ns / 1ps
`default_nettype none

module bpdc_front
    import bpdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    bpdc_req_if.sink         req,
    bpdc_cfg_if.sink         cfg,
    input  wire logic        q_ready,
    output logic             q_push,
    output class_t           q_item
);

    logic [LEVEL_W-1:0] min_level_reg;
    logic [STEP_W-1:0]  dim_step_reg;
    logic [STEP_W-1:0]  tune;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg <= MIN_LEVEL_RST;
            dim_step_reg  <= DIM_STEP_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_MIN_LEVEL: min_level_reg <= cfg.data;
                REG_DIM_STEP:  dim_step_reg  <= cfg.data[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (req.level == '0)
        begin
            tune = '0;
        end
        else if (req.level < min_level_reg)
        begin
            tune = dim_step_reg;
        end
        else
        begin
            tune = table_step(req.level);
        end
    end

    assign req.ready = q_ready;
    assign q_push    = req.valid && q_ready;

    assign q_item.level      = req.level;
    assign q_item.tune       = tune;
    assign q_item.power_on   = req.power_on;
    assign q_item.line_sense = req.line_sense;

endmodule

`default_nettype wire

@@ hdl/bpdc_queue.sv @@
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module bpdc_queue
    import bpdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  class_t      push_item,
    output logic        ready,
    input  wire logic   pop,
    output logic        head_valid,
    output class_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    class_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign ready      = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bpdc_back.sv @@
// Back end: step state, line action decisions and the result register.
`timescale 1ns / 1ps
`default_nettype none

`include "backlight_pulse_dimming_control_macros.svh"

module bpdc_back
    import bpdc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   head_valid,
    input  class_t      head,
    output logic        pop,
    bpdc_rsp_if.source  rsp
);

    logic [LEVEL_W-1:0] last_level_reg;
    logic [LEVEL_W-1:0] last_level_next;
    // The step is unknown until the first applied request after reset.
    logic               known_reg;
    logic               known_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               out_valid_reg;
    result_t            rsp_q_reg;
    result_t            rsp_next;

    assign pop = head_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        last_level_next         = last_level_reg;
        known_next              = known_reg;
        step_next               = step_reg;
        rsp_next.applied        = 1'b0;
        rsp_next.drop_low_first = 1'b0;
        rsp_next.raise_line     = 1'b0;
        rsp_next.pulse_count    = '0;
        rsp_next.line_high      = head.line_sense;

        if (head.power_on && (head.level != last_level_reg))
        begin
            last_level_next = head.level;
            if (!known_reg || (head.tune != step_reg))
            begin
                rsp_next.applied = 1'b1;
                known_next       = 1'b1;
                step_next        = head.tune;
                if (head.tune == '0)
                begin
                    rsp_next.drop_low_first = 1'b1;
                    rsp_next.line_high      = 1'b0;
                end
                else
                begin
                    if (!known_reg && head.line_sense)
                    begin
                        // Unknown driver state: reset it by dropping low, then raise.
                        rsp_next.drop_low_first = 1'b1;
                        rsp_next.raise_line     = 1'b1;
                        rsp_next.pulse_count    = head.tune;
                    end
                    else if (!known_reg)
                    begin
                        rsp_next.pulse_count = head.tune + 1'b1;
                    end
                    else if (step_reg == '0)
                    begin
                        rsp_next.raise_line  = 1'b1;
                        rsp_next.pulse_count = head.tune;
                    end
                    else
                    begin
                        // Modular step distance; the step count is a power of two.
                        rsp_next.pulse_count = head.tune - step_reg;
                    end
                    rsp_next.line_high = rsp_next.raise_line
                                         || (rsp_next.pulse_count != '0)
                                         || head.line_sense;
                end
            end
        end
        rsp_next.new_step = known_next ? step_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= '0;
            known_reg      <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                last_level_reg <= last_level_next;
                known_reg      <= known_next;
                step_reg       <= step_next;
                out_valid_reg  <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rsp_q_reg <= rsp_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.applied        = rsp_q_reg.applied;
    assign rsp.drop_low_first = rsp_q_reg.drop_low_first;
    assign rsp.raise_line     = rsp_q_reg.raise_line;
    assign rsp.pulse_count    = rsp_q_reg.pulse_count;
    assign rsp.new_step       = rsp_q_reg.new_step;
    assign rsp.line_high      = rsp_q_reg.line_high;

    `BPDC_ASSERT(a_raise_pulses, (out_valid_reg && rsp_q_reg.raise_line) |-> (rsp_q_reg.pulse_count == rsp_q_reg.new_step), "raise must be followed by new_step pulses")
    `BPDC_ASSERT(a_idle_actions, (out_valid_reg && !rsp_q_reg.applied) |-> (!rsp_q_reg.drop_low_first && !rsp_q_reg.raise_line && (rsp_q_reg.pulse_count == '0)), "line action on an unapplied item")
    `BPDC_ASSERT(a_known_sticks, known_reg |=> known_reg, "step became unknown after being set")
    `BPDC_NEVER(a_drop_only_off, out_valid_reg && rsp_q_reg.drop_low_first && !rsp_q_reg.raise_line && ((rsp_q_reg.new_step != '0) || rsp_q_reg.line_high), "plain drop must leave the line low at step zero")

endmodule

`default_nettype wire

@@ hdl/backlight_pulse_dimming_control.sv @@
// Top level: one request item in, one line action result item out.
// Path: an accepted request item is written into the queue, then popped by the back end into the result register.
// Throughput: one item per cycle while rsp.ready holds; the back-end step update is the only serial loop.
// The queue between front and back end lets either side stall without losing items.
// Reset: min_level 10, dim_step 31, last level 0, step unknown, queue and result empty.
`timescale 1ns / 1ps
`default_nettype none

module backlight_pulse_dimming_control
    import bpdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bpdc_req_if.sink    req,
    bpdc_rsp_if.source  rsp,
    bpdc_cfg_if.sink    cfg
);

    logic   q_ready;
    logic   q_push;
    class_t q_item;
    logic   q_pop;
    logic   q_head_valid;
    class_t q_head;

    bpdc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .cfg     (cfg),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_item  (q_item)
    );

    bpdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .ready      (q_ready),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    bpdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire
